// ===== sv/mmcd_pkg.sv =====
// Shared types and constants for the min/max column decimator.
// Used by every module of the block; depends on nothing else.

package mmcd_pkg;

    // Default parameter values
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_COLUMNS_DEF = 4096;

    // Configuration register widths and port layout
    localparam int CFG_N_W     = 21;
    localparam int CFG_W_W     = 13;
    localparam int CFG_ROW_W   = 11;
    localparam int CFG_DATA_W  = 21;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_ROW   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_HEIGHT  = 2'd3;

    // Register reset values
    localparam logic [CFG_N_W-1:0]   RST_SAMPLE_COUNT = 21'd1024;
    localparam logic [CFG_W_W-1:0]   RST_COLUMN_COUNT = 13'd1024;
    localparam logic [CFG_ROW_W-1:0] RST_CENTER_ROW   = 11'd60;
    localparam logic [CFG_ROW_W-1:0] RST_HALF_HEIGHT  = 11'd54;

    // Result word layout
    localparam int COLUMN_W   = 12;
    localparam int ROW_W      = 13;
    localparam int SCALED_W   = 12;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;

    // Results produced by one sample at most
    localparam int MAX_OUT      = 64;
    localparam int RESULT_CNT_W = 7;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // One event from the back end to the output stage
    typedef struct packed {
        logic                point;   // 1: new column point, 0: copy of last point
        logic                emit;    // the event produces a result word
        logic                last;    // final result caused by this sample
        logic                fend;    // point of the frame's last column
        logic [COLUMN_W-1:0] column;
    } mmcd_evt_t;

endpackage

// ===== sv/minmax_column_decimator_core.sv =====
// Min/max column decimator: one frame of samples becomes one point per column.
// A sample word is registered in the queue; the back end turns it into events, and the
// output stage registers each result word onto m_tdata.
// Throughput: one sample word per cycle while the queue is not full; every empty column
// that a sample walks over takes its own back-end step, whether or not its copy word is sent.
// Synchronous active-low reset loads register defaults and restarts the frame; a write also restarts the frame.

module minmax_column_decimator_core
    import mmcd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]              cfg_index,
    input  logic [CFG_DATA_W-1:0]               cfg_data,
    // Sample input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // [SAMPLE_BITS-1:0] sample
    // Result output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [OUT_DATA_W-1:0]               m_tdata,  // column, y_upper, y_lower
    output logic                                m_tlast,
    output logic [OUT_USER_W-1:0]               m_tuser   // repeated, frame_end
);

    localparam int WW    = $clog2(MAX_COLUMNS + 1);
    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int ACC_W = CFG_N_W + WW + 1;
    localparam int Q_W   = SAMPLE_BITS + 2 * ACC_W;

    logic [CFG_N_W-1:0]   sample_count_reg;
    logic [CFG_W_W-1:0]   column_count_reg;
    logic [CFG_ROW_W-1:0] center_row_reg;
    logic [CFG_ROW_W-1:0] half_height_reg;
    logic                 restart;

    logic [CFG_N_W-1:0]   n_eff;
    logic [31:0]          col_cnt_ext;
    logic [31:0]          w_clamped;
    logic [WW-1:0]        w_eff;

    logic                 q_full;
    logic                 q_push;
    logic [Q_W-1:0]       q_wdata;
    logic                 q_pop;
    logic [Q_W-1:0]       q_rdata;
    logic                 q_valid;

    logic                   evt_ready;
    logic                   evt_valid;
    mmcd_evt_t              evt;
    logic [SAMPLE_BITS-1:0] evt_max;
    logic [SAMPLE_BITS-1:0] evt_min;

    // Register writes; every valid index restarts the frame.
    always_comb begin
        unique case (cfg_index)
            REG_SAMPLE_COUNT,
            REG_COLUMN_COUNT,
            REG_CENTER_ROW,
            REG_HALF_HEIGHT: restart = cfg_wr_en;
            default:         restart = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= RST_SAMPLE_COUNT;
            column_count_reg <= RST_COLUMN_COUNT;
            center_row_reg   <= RST_CENTER_ROW;
            half_height_reg  <= RST_HALF_HEIGHT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SAMPLE_COUNT: sample_count_reg <= cfg_data[CFG_N_W-1:0];
                REG_COLUMN_COUNT: column_count_reg <= cfg_data[CFG_W_W-1:0];
                REG_CENTER_ROW:   center_row_reg   <= cfg_data[CFG_ROW_W-1:0];
                REG_HALF_HEIGHT:  half_height_reg  <= cfg_data[CFG_ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective sample and column counts
    assign n_eff       = (sample_count_reg == '0) ? CFG_N_W'(1) : sample_count_reg;
    assign col_cnt_ext = 32'(column_count_reg);

    always_comb begin
        if (col_cnt_ext == 32'd0) begin
            w_clamped = 32'd1;
        end else if (col_cnt_ext > 32'(MAX_COLUMNS)) begin
            w_clamped = 32'(MAX_COLUMNS);
        end else begin
            w_clamped = col_cnt_ext;
        end
    end

    assign w_eff = w_clamped[WW-1:0];

    mmcd_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WW          (WW),
        .ACC_W       (ACC_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .restart  (restart),
        .n_eff    (n_eff),
        .w_eff    (w_eff),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sample   (s_tdata[SAMPLE_BITS-1:0]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    mmcd_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wdata     (q_wdata),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .full      (q_full),
        .not_empty (q_valid)
    );

    mmcd_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WW          (WW),
        .CW          (CW),
        .ACC_W       (ACC_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .restart   (restart),
        .n_eff     (n_eff),
        .w_eff     (w_eff),
        .q_valid   (q_valid),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .evt_ready (evt_ready),
        .evt_valid (evt_valid),
        .evt       (evt),
        .evt_max   (evt_max),
        .evt_min   (evt_min)
    );

    mmcd_out #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .center_row  (center_row_reg),
        .half_height (half_height_reg),
        .evt_valid   (evt_valid),
        .evt         (evt),
        .evt_max     (evt_max),
        .evt_min     (evt_min),
        .evt_ready   (evt_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== sv/mmcd_queue.sv =====
// Small register FIFO that decouples the front end from the back end.
// Depends on mmcd_pkg for its default depth; generic width and depth.

module mmcd_queue
    import mmcd_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             not_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rdata     = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== sv/mmcd_front.sv =====
// Front end: accepts samples and tags each with its column boundary limits.
// Depends on mmcd_pkg; feeds mmcd_queue.

module mmcd_front
    import mmcd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int WW          = 13,
    parameter int ACC_W       = 35
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             restart,
    input  logic [CFG_N_W-1:0]               n_eff,
    input  logic [WW-1:0]                    w_eff,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [SAMPLE_BITS-1:0]           sample,
    input  logic                             q_full,
    output logic                             q_push,
    output logic [SAMPLE_BITS+2*ACC_W-1:0]   q_wdata
);

    logic [CFG_N_W-1:0] idx_reg;
    logic [CFG_N_W-1:0] idx_next;
    logic [ACC_W-1:0]   tacc_reg;
    logic [ACC_W-1:0]   tacc_next;
    logic               fresh_reg;
    logic               fresh_next;
    logic [ACC_W-1:0]   t1;
    logic [ACC_W-1:0]   t2;
    logic [CFG_N_W:0]   idx_inc;
    logic               wrap;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // A fresh frame starts with (index + 1) * W equal to W.
    assign t1      = fresh_reg ? ACC_W'(w_eff) : tacc_reg;
    assign t2      = t1 + ACC_W'(w_eff);
    assign idx_inc = {1'b0, idx_reg} + 1'b1;
    assign wrap    = (idx_inc >= {1'b0, n_eff});
    assign q_wdata = {t2, t1, sample};

    // Sample index and running (index + 1) * W
    always_comb begin
        idx_next   = idx_reg;
        tacc_next  = tacc_reg;
        fresh_next = fresh_reg;
        if (q_push) begin
            if (wrap) begin
                idx_next   = '0;
                fresh_next = 1'b1;
            end else begin
                idx_next   = idx_inc[CFG_N_W-1:0];
                tacc_next  = t2;
                fresh_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            idx_reg   <= '0;
            fresh_reg <= 1'b1;
        end else begin
            idx_reg   <= idx_next;
            fresh_reg <= fresh_next;
        end
    end

    always_ff @(posedge aclk) begin
        tacc_reg <= tacc_next;
    end

endmodule

// ===== sv/mmcd_back.sv =====
// Back end: walks the columns, tracks extremes and issues point and copy events.
// Depends on mmcd_pkg; reads mmcd_queue and drives mmcd_out.

module mmcd_back
    import mmcd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int WW          = 13,
    parameter int CW          = 12,
    parameter int ACC_W       = 35
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           restart,
    input  logic [CFG_N_W-1:0]             n_eff,
    input  logic [WW-1:0]                  w_eff,
    input  logic                           q_valid,
    input  logic [SAMPLE_BITS+2*ACC_W-1:0] q_rdata,
    output logic                           q_pop,
    input  logic                           evt_ready,
    output logic                           evt_valid,
    output mmcd_evt_t                      evt,
    output logic [SAMPLE_BITS-1:0]         evt_max,
    output logic [SAMPLE_BITS-1:0]         evt_min
);

    localparam logic PH_MAIN = 1'b0;
    localparam logic PH_POST = 1'b1;

    localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    logic                    phase_reg, phase_next;
    logic [CW-1:0]           col_reg, col_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic                    fresh_reg, fresh_next;
    logic                    pt_valid_reg, pt_valid_next;
    logic [RESULT_CNT_W-1:0] k_reg, k_next;
    logic [SAMPLE_BITS-1:0]  max_reg, max_next;
    logic [SAMPLE_BITS-1:0]  min_reg, min_next;

    logic [SAMPLE_BITS-1:0]  smp;
    logic [ACC_W-1:0]        t1;
    logic [ACC_W-1:0]        t2;
    logic [ACC_W-1:0]        acc_cur;
    logic [ACC_W-1:0]        acc_inc;
    logic [WW:0]             col_p1;
    logic [WW:0]             col_p2;
    logic                    has_next_col;
    logic                    more_after;
    logic                    pre;
    logic                    close;
    logic                    room;
    logic                    cap_last;
    logic                    fire;
    logic [SAMPLE_BITS-1:0]  new_max;
    logic [SAMPLE_BITS-1:0]  new_min;

    // Unpack the queue word
    assign smp = q_rdata[SAMPLE_BITS-1:0];
    assign t1  = q_rdata[SAMPLE_BITS+ACC_W-1:SAMPLE_BITS];
    assign t2  = q_rdata[SAMPLE_BITS+2*ACC_W-1:SAMPLE_BITS+ACC_W];

    // Boundary accumulator holds (column + 1) * N; a fresh frame reads as N.
    assign acc_cur = fresh_reg ? ACC_W'(n_eff) : acc_reg;
    assign acc_inc = acc_cur + ACC_W'(n_eff);

    // Column tests against the effective column count
    assign col_p1       = (WW+1)'(col_reg) + 1'b1;
    assign col_p2       = (WW+1)'(col_reg) + 2'd2;
    assign has_next_col = (col_p1 < {1'b0, w_eff});
    assign more_after   = (col_p2 < {1'b0, w_eff}) && (acc_inc < t2);
    assign pre          = has_next_col && (acc_cur < t1);
    assign close        = (acc_cur < t2);

    // Result budget for the current sample
    assign room     = (k_reg < RESULT_CNT_W'(MAX_OUT));
    assign cap_last = (k_reg == RESULT_CNT_W'(MAX_OUT - 1));

    assign new_max = ($signed(smp) > $signed(max_reg)) ? smp : max_reg;
    assign new_min = ($signed(smp) < $signed(min_reg)) ? smp : min_reg;

    assign fire    = q_valid && evt_ready;
    assign evt_max = new_max;
    assign evt_min = new_min;

    // One step per cycle if not stalled: empty column, sample or trailing copy.
    always_comb begin
        phase_next    = phase_reg;
        col_next      = col_reg;
        acc_next      = acc_reg;
        fresh_next    = fresh_reg;
        pt_valid_next = pt_valid_reg;
        k_next        = k_reg;
        max_next      = max_reg;
        min_next      = min_reg;
        q_pop         = 1'b0;
        evt_valid     = 1'b0;
        evt.point     = 1'b0;
        evt.emit      = 1'b0;
        evt.last      = 1'b0;
        evt.fend      = 1'b0;
        evt.column    = COLUMN_W'(col_reg);
        if (fire) begin
            unique case (phase_reg)
                PH_MAIN: begin
                    if (pre) begin
                        // Empty column ahead of this sample
                        col_next   = col_reg + 1'b1;
                        acc_next   = acc_inc;
                        fresh_next = 1'b0;
                        if (pt_valid_reg && room) begin
                            evt_valid = 1'b1;
                            evt.emit  = 1'b1;
                            evt.last  = cap_last || !(acc_inc < t2);
                            k_next    = k_reg + 1'b1;
                        end
                    end else if (close) begin
                        // The sample closes the current column.
                        evt_valid = 1'b1;
                        evt.point = 1'b1;
                        evt.emit  = room;
                        evt.fend  = !has_next_col;
                        evt.last  = cap_last || !has_next_col || !more_after;
                        max_next  = S_MIN;
                        min_next  = S_MAX;
                        if (!has_next_col) begin
                            col_next      = '0;
                            fresh_next    = 1'b1;
                            pt_valid_next = 1'b0;
                            q_pop         = 1'b1;
                            k_next        = '0;
                        end else begin
                            col_next      = col_reg + 1'b1;
                            acc_next      = acc_inc;
                            fresh_next    = 1'b0;
                            pt_valid_next = 1'b1;
                            if (more_after) begin
                                phase_next = PH_POST;
                                k_next     = room ? k_reg + 1'b1 : k_reg;
                            end else begin
                                q_pop  = 1'b1;
                                k_next = '0;
                            end
                        end
                    end else begin
                        // Sample inside the column
                        max_next = new_max;
                        min_next = new_min;
                        q_pop    = 1'b1;
                        k_next   = '0;
                    end
                end
                PH_POST: begin
                    // Empty columns that end on this sample repeat the point.
                    col_next   = col_reg + 1'b1;
                    acc_next   = acc_inc;
                    fresh_next = 1'b0;
                    if (room) begin
                        evt_valid = 1'b1;
                        evt.emit  = 1'b1;
                        evt.last  = cap_last || !more_after;
                        k_next    = k_reg + 1'b1;
                    end
                    if (!more_after) begin
                        phase_next = PH_MAIN;
                        q_pop      = 1'b1;
                        k_next     = '0;
                    end
                end
                default: begin
                    phase_next = PH_MAIN;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            phase_reg    <= PH_MAIN;
            col_reg      <= '0;
            fresh_reg    <= 1'b1;
            pt_valid_reg <= 1'b0;
            k_reg        <= '0;
            max_reg      <= S_MIN;
            min_reg      <= S_MAX;
        end else begin
            phase_reg    <= phase_next;
            col_reg      <= col_next;
            fresh_reg    <= fresh_next;
            pt_valid_reg <= pt_valid_next;
            k_reg        <= k_next;
            max_reg      <= max_next;
            min_reg      <= min_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

endmodule

// ===== sv/mmcd_out.sv =====
// Output stage: scales extremes to screen rows and holds the result word.
// Depends on mmcd_pkg; takes events from mmcd_back.

module mmcd_out
    import mmcd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [CFG_ROW_W-1:0]   center_row,
    input  logic [CFG_ROW_W-1:0]   half_height,
    input  logic                   evt_valid,
    input  mmcd_evt_t              evt,
    input  logic [SAMPLE_BITS-1:0] evt_max,
    input  logic [SAMPLE_BITS-1:0] evt_min,
    output logic                   evt_ready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic                   m_tlast,
    output logic [OUT_USER_W-1:0]  m_tuser
);

    localparam int PROD_W = SAMPLE_BITS + CFG_ROW_W + 1;

    logic signed [PROD_W-1:0]   prod_up;
    logic signed [PROD_W-1:0]   prod_lo;
    logic signed [SCALED_W-1:0] scaled_up;
    logic signed [SCALED_W-1:0] scaled_lo;
    logic [ROW_W-1:0]           row_up;
    logic [ROW_W-1:0]           row_lo;
    logic [ROW_W-1:0]           center_ext;

    logic                  tvalid_reg;
    logic [OUT_DATA_W-1:0] tdata_reg;
    logic                  tlast_reg;
    logic [OUT_USER_W-1:0] tuser_reg;
    logic [COLUMN_W-1:0]   last_col_reg;
    logic [ROW_W-1:0]      last_up_reg;
    logic [ROW_W-1:0]      last_lo_reg;
    logic [COLUMN_W-1:0]   sel_col;
    logic [ROW_W-1:0]      sel_up;
    logic [ROW_W-1:0]      sel_lo;

    assign evt_ready = !tvalid_reg || m_tready;
    assign m_tvalid  = tvalid_reg;
    assign m_tdata   = tdata_reg;
    assign m_tlast   = tlast_reg;
    assign m_tuser   = tuser_reg;

    // Row = center - floor(v * half / 2^(SAMPLE_BITS-1))
    assign prod_up    = $signed(evt_max) * $signed({1'b0, half_height});
    assign prod_lo    = $signed(evt_min) * $signed({1'b0, half_height});
    assign scaled_up  = prod_up[SAMPLE_BITS+SCALED_W-2:SAMPLE_BITS-1];
    assign scaled_lo  = prod_lo[SAMPLE_BITS+SCALED_W-2:SAMPLE_BITS-1];
    assign center_ext = {{(ROW_W-CFG_ROW_W){1'b0}}, center_row};
    assign row_up     = center_ext - {scaled_up[SCALED_W-1], scaled_up};
    assign row_lo     = center_ext - {scaled_lo[SCALED_W-1], scaled_lo};

    // A copy repeats the stored point.
    assign sel_col = evt.point ? evt.column : last_col_reg;
    assign sel_up  = evt.point ? row_up : last_up_reg;
    assign sel_lo  = evt.point ? row_lo : last_lo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg <= 1'b0;
        end else if (evt_valid && evt.emit) begin
            tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            tvalid_reg <= 1'b0;
        end
    end

    // Result word and the last point, kept even when its word is dropped
    always_ff @(posedge aclk) begin
        if (evt_valid && evt.emit) begin
            tdata_reg <= {{(OUT_DATA_W-COLUMN_W-2*ROW_W){1'b0}}, sel_lo, sel_up, sel_col};
            tlast_reg <= evt.last;
            tuser_reg <= {evt.fend, !evt.point};
        end
        if (evt_valid && evt.point) begin
            last_col_reg <= evt.column;
            last_up_reg  <= row_up;
            last_lo_reg  <= row_lo;
        end
    end

endmodule
